### rtl/htok_pkg.sv
// Shared types and constants for the HTTP method and path tokenizer.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package htok_pkg;

  typedef enum logic [1:0] {
    REC_BYTE = 2'd0,
    REC_END  = 2'd1,
    REC_SUM  = 2'd2
  } rec_kind_e;

  typedef enum logic [2:0] {
    METH_UNKNOWN = 3'd0,
    METH_GET     = 3'd1,
    METH_POST    = 3'd2,
    METH_PUT     = 3'd3,
    METH_DELETE  = 3'd4
  } meth_e;

  // Records that one input byte produces, always in the order byte, end, summary.
  typedef struct packed {
    logic       has_byte;
    logic       has_end;
    logic       has_sum;
    meth_e      meth;
    logic [2:0] tok;
    logic [4:0] pos;
    logic [7:0] data;
    logic [5:0] len;
    logic [3:0] found;
    logic       err;
    logic       ovf;
  } bundle_t;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

endpackage

### rtl/htok_front.sv
// Front end of the tokenizer: method matching, path splitting and request state.
// Turns each accepted byte into one record bundle; depends on htok_pkg.
module htok_front #(
  parameter int unsigned MAX_TOKENS    = 8,
  parameter int unsigned MAX_TOKEN_LEN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_text_i,
  output htok_pkg::bundle_t bundle_o
);
  import htok_pkg::*;

  localparam int unsigned TokW = $clog2(MAX_TOKENS + 1);
  localparam int unsigned ChrW = $clog2(MAX_TOKEN_LEN + 1);

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic [3:0] {
    PH_MATCH = 4'b0001,
    PH_SEEK  = 4'b0010,
    PH_PATH  = 4'b0100,
    PH_DRAIN = 4'b1000
  } phase_e;

  function automatic logic [2:0] cand_len(input int unsigned idx);
    logic [2:0] len;
    case (idx)
      0:       len = 3'd3;
      1:       len = 3'd4;
      2:       len = 3'd3;
      3:       len = 3'd5;
      default: len = 3'd6;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] cand_char(input int unsigned idx, input logic [2:0] pos);
    logic [47:0] txt;
    logic [2:0]  sel;
    case (idx)
      0:       txt = 48'("GET");
      1:       txt = 48'("POST");
      2:       txt = 48'("PUT");
      3:       txt = 48'("PATCH");
      default: txt = 48'("DELETE");
    endcase
    sel = cand_len(idx) - 3'd1 - pos;
    return txt[8 * sel +: 8];
  endfunction

  function automatic meth_e cand_code(input int unsigned idx);
    meth_e code;
    case (idx)
      0:       code = METH_GET;
      1:       code = METH_POST;
      2:       code = METH_PUT;
      3:       code = METH_PUT;
      default: code = METH_DELETE;
    endcase
    return code;
  endfunction

  phase_e            phase_q, phase_d;
  logic [4:0]        cand_q, cand_d;
  logic [2:0]        pfx_q, pfx_d;
  meth_e             meth_q, meth_d;
  logic [TokW-1:0]   tok_q, tok_d;
  logic [ChrW-1:0]   chr_q, chr_d;
  logic              ovf_q, ovf_d;
  bundle_t           bnd;

  always_comb begin
    logic       eot;
    logic       delim;
    logic       slash;
    logic [4:0] alive;
    logic       hit;
    meth_e      hit_code;
    logic       do_sum;
    logic       sum_err;

    phase_d  = phase_q;
    cand_d   = cand_q;
    pfx_d    = pfx_q;
    meth_d   = meth_q;
    tok_d    = tok_q;
    chr_d    = chr_q;
    ovf_d    = ovf_q;
    bnd      = '0;
    do_sum   = 1'b0;
    sum_err  = 1'b0;
    alive    = '0;
    hit      = 1'b0;
    hit_code = METH_UNKNOWN;

    eot   = end_of_text_i || (text_byte_i == ChNul);
    slash = (text_byte_i == ChSlash);
    delim = (text_byte_i == ChNul) || (text_byte_i == ChSpace) || (text_byte_i == ChCr) ||
            (text_byte_i == ChLf) || (text_byte_i == ChTab);

    case (phase_q)
      PH_MATCH: begin
        if (text_byte_i == ChNul) begin
          do_sum  = 1'b1;
          sum_err = 1'b1;
        end else begin
          for (int unsigned i = 0; i < 5; i++) begin
            alive[i] = cand_q[i] && (pfx_q < cand_len(i)) &&
                       (cand_char(i, pfx_q) == text_byte_i);
            if (alive[i] && (pfx_q + 3'd1 == cand_len(i)) && !hit) begin
              hit      = 1'b1;
              hit_code = cand_code(i);
            end
          end
          cand_d = alive;
          pfx_d  = pfx_q + 3'd1;
          if (hit) begin
            meth_d = hit_code;
            if (hit_code == METH_POST) begin
              phase_d = PH_SEEK;
              do_sum  = eot;
            end else begin
              do_sum = 1'b1;
            end
          end else if ((alive == '0) || eot) begin
            do_sum  = 1'b1;
            sum_err = 1'b1;
          end
        end
      end
      PH_SEEK: begin
        if (eot) begin
          do_sum = 1'b1;
        end else if (slash) begin
          phase_d = PH_PATH;
        end
      end
      PH_PATH: begin
        bnd.tok = 3'(tok_q);
        if (!delim && !slash) begin
          if (chr_q < ChrW'(MAX_TOKEN_LEN)) begin
            bnd.has_byte = 1'b1;
            bnd.pos      = 5'(chr_q);
            bnd.data     = text_byte_i;
            chr_d        = chr_q + ChrW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        // A delimiter, a slash or the end of the request closes a non-empty token.
        if ((delim || slash || eot) && (chr_d != '0)) begin
          bnd.has_end = 1'b1;
          bnd.len     = 6'(chr_d);
          tok_d       = tok_q + TokW'(1);
          chr_d       = '0;
        end
        do_sum = delim || eot || (slash && (tok_d >= TokW'(MAX_TOKENS)));
      end
      PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    if (do_sum) begin
      bnd.has_sum = 1'b1;
      bnd.found   = 4'(tok_d);
      bnd.err     = sum_err;
      bnd.ovf     = ovf_d;
      phase_d     = PH_DRAIN;
    end
    bnd.meth = meth_d;

    if (eot) begin
      phase_d = PH_MATCH;
      cand_d  = '1;
      pfx_d   = '0;
      meth_d  = METH_UNKNOWN;
      tok_d   = '0;
      chr_d   = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MATCH;
      cand_q  <= '1;
      pfx_q   <= '0;
      meth_q  <= METH_UNKNOWN;
      tok_q   <= '0;
      chr_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cand_q  <= cand_d;
      pfx_q   <= pfx_d;
      meth_q  <= meth_d;
      tok_q   <= tok_d;
      chr_q   <= chr_d;
      ovf_q   <= ovf_d;
    end
  end

  assign bundle_o = bnd;

endmodule

### rtl/htok_queue.sv
// Short queue of record bundles between the front and back parts of the tokenizer.
// Depends on htok_pkg for the bundle type and the queue depth.
module htok_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  htok_pkg::bundle_t data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              head_valid_o,
  output htok_pkg::bundle_t head_o
);
  import htok_pkg::*;

  bundle_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]     count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QueuePtrW + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QueuePtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o       = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

endmodule

### rtl/htok_back.sv
// Back end of the tokenizer: walks each queued bundle and issues its records one per cycle
// while the output is not stalled. Holds the output register; depends on htok_pkg.
module htok_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  htok_pkg::bundle_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output htok_pkg::rec_kind_e record_kind_o,
  output htok_pkg::meth_e   method_code_o,
  output logic [2:0]        token_number_o,
  output logic [4:0]        byte_position_o,
  output logic [7:0]        token_byte_o,
  output logic [5:0]        token_length_o,
  output logic [3:0]        tokens_found_o,
  output logic              method_error_o,
  output logic              length_overflow_o,
  output logic              last_of_run_o
);
  import htok_pkg::*;

  logic       byte_done_q, end_done_q;
  logic       load;
  logic       last;
  rec_kind_e  kind;

  logic       out_valid_q;
  rec_kind_e  kind_q;
  meth_e      meth_q;
  logic [2:0] tok_q;
  logic [4:0] pos_q;
  logic [7:0] data_q;
  logic [5:0] len_q;
  logic [3:0] found_q;
  logic       err_q, ovf_q, last_q;

  always_comb begin
    if (head_i.has_byte && !byte_done_q) begin
      kind = REC_BYTE;
      last = !head_i.has_end && !head_i.has_sum;
    end else if (head_i.has_end && !end_done_q) begin
      kind = REC_END;
      last = !head_i.has_sum;
    end else begin
      kind = REC_SUM;
      last = 1'b1;
    end
  end

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_done_q <= 1'b0;
      end_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (last) begin
          byte_done_q <= 1'b0;
          end_done_q  <= 1'b0;
        end else if (kind == REC_BYTE) begin
          byte_done_q <= 1'b1;
        end else begin
          end_done_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Fields that do not belong to the record kind are given as zero.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind;
      meth_q  <= head_i.meth;
      tok_q   <= (kind != REC_SUM) ? head_i.tok : 3'd0;
      pos_q   <= (kind == REC_BYTE) ? head_i.pos : 5'd0;
      data_q  <= (kind == REC_BYTE) ? head_i.data : 8'd0;
      len_q   <= (kind == REC_END) ? head_i.len : 6'd0;
      found_q <= (kind == REC_SUM) ? head_i.found : 4'd0;
      err_q   <= (kind == REC_SUM) && head_i.err;
      ovf_q   <= (kind == REC_SUM) && head_i.ovf;
      last_q  <= last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign record_kind_o     = kind_q;
  assign method_code_o     = meth_q;
  assign token_number_o    = tok_q;
  assign byte_position_o   = pos_q;
  assign token_byte_o      = data_q;
  assign token_length_o    = len_q;
  assign tokens_found_o    = found_q;
  assign method_error_o    = err_q;
  assign length_overflow_o = ovf_q;
  assign last_of_run_o     = last_q;

endmodule

### rtl/http_method_and_path_tokenizer.sv
// Top level of the HTTP method and path tokenizer.
// Instantiates htok_front, htok_queue and htok_back; depends on htok_pkg.

// The block takes one request byte per transfer and may take a byte in every cycle. A front
// stage recognizes the method (GET, POST, PUT, PATCH reported as PUT, DELETE), skips to the
// first slash for POST, and splits the path into slash-separated tokens. Each byte becomes a
// bundle of zero to three records (token byte, token end, summary) that is written into a
// four-entry queue. The back stage issues one record per cycle from the head of the queue
// into an output register while the output is not stalled, so a byte that yields two or
// three records holds the back stage longer than one that yields one record or none, and
// the input stalls only when the queue is full. The first record of a byte is written into
// the queue and then into the output register before it is presented, and it is taken when
// out_stall_i is low. A zero byte or a set end_of_text ends the request, and the next byte
// starts a new one. MAX_TOKENS bounds the number of tokens per request and MAX_TOKEN_LEN the
// stored length of a token; longer tokens are cut and the summary reports length_overflow.
module http_method_and_path_tokenizer #(
  parameter int unsigned MAX_TOKENS    = 8,
  parameter int unsigned MAX_TOKEN_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] record_kind_o,
  output logic [2:0] method_code_o,
  output logic [2:0] token_number_o,
  output logic [4:0] byte_position_o,
  output logic [7:0] token_byte_o,
  output logic [5:0] token_length_o,
  output logic [3:0] tokens_found_o,
  output logic       method_error_o,
  output logic       length_overflow_o,
  output logic       last_of_run_o
);
  import htok_pkg::*;

  logic      in_accept;
  bundle_t   front_bnd;
  logic      q_push, q_pop, q_full, q_head_valid;
  bundle_t   q_head;
  rec_kind_e kind;
  meth_e     meth;

  // The input stalls only on a full queue, independent of the output side this cycle.
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  // Bytes that produce no record leave nothing in the queue.
  assign q_push = in_accept && (front_bnd.has_byte || front_bnd.has_end || front_bnd.has_sum);

  htok_front #(
    .MAX_TOKENS   (MAX_TOKENS),
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .bundle_o     (front_bnd)
  );

  htok_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .data_i      (front_bnd),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .head_valid_o(q_head_valid),
    .head_o      (q_head)
  );

  htok_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (q_head_valid),
    .head_i           (q_head),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .record_kind_o    (kind),
    .method_code_o    (meth),
    .token_number_o   (token_number_o),
    .byte_position_o  (byte_position_o),
    .token_byte_o     (token_byte_o),
    .token_length_o   (token_length_o),
    .tokens_found_o   (tokens_found_o),
    .method_error_o   (method_error_o),
    .length_overflow_o(length_overflow_o),
    .last_of_run_o    (last_of_run_o)
  );

  assign record_kind_o = kind;
  assign method_code_o = meth;

  // The queue is never written while it is full.
  ap_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("queue written while full");

  // A bundle leaves the queue only when one is there.
  ap_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head_valid)
    else $error("queue read while empty");

  // A summary always closes the records of its byte.
  ap_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind == REC_SUM)) |-> last_of_run_o)
    else $error("summary record not marked last");

  // A method error is only reported when no method was recognized.
  ap_err_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && method_error_o) |-> (meth == METH_UNKNOWN))
    else $error("method error with a known method code");

endmodule

### test/htok_record_checker.sv
// Record checker for the HTTP method and path tokenizer testbench.
// Watches both channels, predicts the records of each byte and compares them.
// Depends on htok_pkg for the record kind and method codes.
module htok_record_checker
  import htok_pkg::*;
#(
  parameter int unsigned MAX_TOKENS    = 8,
  parameter int unsigned MAX_TOKEN_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] record_kind_i,
  input  logic [2:0] method_code_i,
  input  logic [2:0] token_number_i,
  input  logic [4:0] byte_position_i,
  input  logic [7:0] token_byte_i,
  input  logic [5:0] token_length_i,
  input  logic [3:0] tokens_found_i,
  input  logic       method_error_i,
  input  logic       length_overflow_i,
  input  logic       last_of_run_i,
  output int         fail_count_o,
  output int         outstanding_o,
  output int         records_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChTab   = 8'h09;

  typedef enum logic [1:0] {
    ScanMethod,
    ScanSeek,
    ScanPath,
    ScanDrain
  } scan_e;

  typedef struct packed {
    rec_kind_e  kind;
    meth_e      meth;
    logic [2:0] tok;
    logic [4:0] pos;
    logic [7:0] data;
    logic [5:0] len;
    logic [3:0] found;
    logic       err;
    logic       ovf;
    logic       last;
  } record_t;

  string       method_name  [5];
  meth_e       method_value [5];

  scan_e       scan;
  logic [4:0]  alive;
  int unsigned prefix_pos;
  meth_e       found_meth;
  int unsigned tok_cnt;
  int unsigned chr_cnt;
  logic        ovf_seen;

  record_t     byte_records [$];
  record_t     expected_records [$];
  int          n_fail = 0;
  int          n_checked = 0;

  initial begin
    method_name[0] = "GET";
    method_name[1] = "POST";
    method_name[2] = "PUT";
    method_name[3] = "PATCH";
    method_name[4] = "DELETE";
    method_value[0] = METH_GET;
    method_value[1] = METH_POST;
    method_value[2] = METH_PUT;
    method_value[3] = METH_PUT;
    method_value[4] = METH_DELETE;
  end

  function automatic void clear_scan();
    scan       = ScanMethod;
    alive      = 5'b11111;
    prefix_pos = 0;
    found_meth = METH_UNKNOWN;
    tok_cnt    = 0;
    chr_cnt    = 0;
    ovf_seen   = 1'b0;
  endfunction

  function automatic void push_record(rec_kind_e kind, logic [2:0] tok, logic [4:0] pos,
                                      logic [7:0] data, logic [5:0] len, logic [3:0] found,
                                      logic err, logic ovf);
    record_t r;
    r.kind  = kind;
    r.meth  = found_meth;
    r.tok   = tok;
    r.pos   = pos;
    r.data  = data;
    r.len   = len;
    r.found = found;
    r.err   = err;
    r.ovf   = ovf;
    r.last  = 1'b0;
    byte_records.push_back(r);
  endfunction

  // The summary closes the request; later bytes give nothing until the end of text.
  function automatic void give_summary(logic err);
    push_record(REC_SUM, '0, '0, '0, '0, tok_cnt[3:0], err, ovf_seen);
    scan = ScanDrain;
  endfunction

  // An empty token gives no end record, so doubled slashes are skipped.
  function automatic void finish_token();
    if (chr_cnt > 0) begin
      push_record(REC_END, tok_cnt[2:0], '0, '0, chr_cnt[5:0], '0, 1'b0, 1'b0);
      tok_cnt++;
      chr_cnt = 0;
    end
  endfunction

  // Works out the records that one accepted byte produces and queues them.
  function automatic void tokenize_byte(logic [7:0] b, logic eot_flag);
    logic [4:0] next_alive;
    int         hit;
    logic       eot;
    eot = eot_flag || b == ChNul;
    byte_records.delete();
    case (scan)
      ScanMethod: begin
        if (b == ChNul) begin
          give_summary(1'b1);
        end else begin
          next_alive = '0;
          hit = -1;
          for (int i = 0; i < 5; i++) begin
            if (alive[i] && prefix_pos < method_name[i].len()
                && method_name[i][prefix_pos] == b) begin
              next_alive[i] = 1'b1;
              if (prefix_pos + 1 == method_name[i].len() && hit < 0) hit = i;
            end
          end
          alive = next_alive;
          prefix_pos = (prefix_pos + 1) & 7;
          if (hit >= 0) begin
            found_meth = method_value[hit];
            if (found_meth == METH_POST) begin
              scan = ScanSeek;
              if (eot) give_summary(1'b0);
            end else begin
              give_summary(1'b0);
            end
          end else if (next_alive == '0 || eot) begin
            give_summary(1'b1);
          end
        end
      end
      ScanSeek: begin
        if (b == ChSlash) scan = ScanPath;
        else if (eot) give_summary(1'b0);
        if (scan == ScanPath && eot) give_summary(1'b0);
      end
      ScanPath: begin
        if (b == ChNul || b == ChSpace || b == ChCr || b == ChLf || b == ChTab) begin
          finish_token();
          give_summary(1'b0);
        end else begin
          if (b == ChSlash) begin
            finish_token();
            if (tok_cnt >= MAX_TOKENS) give_summary(1'b0);
          end else if (chr_cnt < MAX_TOKEN_LEN) begin
            push_record(REC_BYTE, tok_cnt[2:0], chr_cnt[4:0], b, '0, '0, 1'b0, 1'b0);
            chr_cnt++;
          end else begin
            ovf_seen = 1'b1;
          end
          if (scan == ScanPath && eot) begin
            finish_token();
            give_summary(1'b0);
          end
        end
      end
      default: ;
    endcase
    if (byte_records.size() > 0) byte_records[byte_records.size() - 1].last = 1'b1;
    foreach (byte_records[k]) expected_records.push_back(byte_records[k]);
    if (eot) clear_scan();
  endfunction

  always @(posedge clk_i) begin
    record_t got;
    record_t want;
    logic    bad;
    if (!rst_ni) begin
      clear_scan();
      expected_records.delete();
    end else begin
      // A byte's first record passes through the queue and the output register after its
      // transfer, so the output side never needs the prediction made at the same edge.
      if (out_valid_i && !out_stall_i) begin
        got.kind  = rec_kind_e'(record_kind_i);
        got.meth  = meth_e'(method_code_i);
        got.tok   = token_number_i;
        got.pos   = byte_position_i;
        got.data  = token_byte_i;
        got.len   = token_length_i;
        got.found = tokens_found_i;
        got.err   = method_error_i;
        got.ovf   = length_overflow_i;
        got.last  = last_of_run_i;
        if (expected_records.size() == 0) begin
          if (n_fail < 10)
            $display("%0t: record with none expected: kind=%0d meth=%0d tok=%0d pos=%0d",
                     $time, got.kind, got.meth, got.tok, got.pos);
          n_fail++;
        end else begin
          want = expected_records.pop_front();
          n_checked++;
          bad = (got.kind !== want.kind) || (got.meth !== want.meth)
             || (got.tok !== want.tok) || (got.pos !== want.pos)
             || (got.data !== want.data) || (got.len !== want.len)
             || (got.found !== want.found) || (got.err !== want.err)
             || (got.ovf !== want.ovf) || (got.last !== want.last);
          if (bad) begin
            if (n_fail < 10) begin
              $display("%0t: record mismatch, expected kind=%0d meth=%0d tok=%0d pos=%0d",
                       $time, want.kind, want.meth, want.tok, want.pos,
                       " byte=%02h len=%0d found=%0d err=%0d ovf=%0d last=%0d",
                       want.data, want.len, want.found, want.err, want.ovf, want.last);
              $display("%0t:                  actual kind=%0d meth=%0d tok=%0d pos=%0d",
                       $time, got.kind, got.meth, got.tok, got.pos,
                       " byte=%02h len=%0d found=%0d err=%0d ovf=%0d last=%0d",
                       got.data, got.len, got.found, got.err, got.ovf, got.last);
            end
            n_fail++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) tokenize_byte(text_byte_i, end_of_text_i);
    end
    fail_count_o      <= n_fail;
    outstanding_o     <= expected_records.size();
    records_checked_o <= n_checked;
  end

endmodule

### test/tb_http_method_and_path_tokenizer.sv
// Testbench top for the HTTP method and path tokenizer.
// Drives request bytes and the output stall, and gives the verdict; depends on htok_pkg,
// htok_record_checker and the http_method_and_path_tokenizer RTL.
module tb_http_method_and_path_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxTokens     = 8;
  localparam int unsigned MaxTokenLen   = 32;
  localparam int          ItemTarget    = 420;
  localparam int          HoldCycles    = 80;
  localparam int          TailCycles    = 12;
  localparam int          WatchdogLimit = 1000;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChTab   = 8'h09;

  // Every input of the block has a known value from time zero on.
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [7:0] text_byte_i   = '0;
  logic       end_of_text_i = 1'b0;
  logic       out_stall_i   = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] record_kind_o;
  logic [2:0] method_code_o;
  logic [2:0] token_number_o;
  logic [4:0] byte_position_o;
  logic [7:0] token_byte_o;
  logic [5:0] token_length_o;
  logic [3:0] tokens_found_o;
  logic       method_error_o;
  logic       length_overflow_o;
  logic       last_of_run_o;

  int         fail_count;
  int         outstanding;
  int         records_checked;

  // Idling percentages and the long-hold request are set by the sender; the receiver
  // process acts on the stall percentage and the hold request, the sender on its idle one.
  int         send_idle_pct  = 7;
  int         recv_stall_pct = 81;
  bit         hold_request   = 1'b0;

  logic [7:0] text_q [$];
  int         bytes_sent = 0;
  int         requests   = 0;
  int         idle_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  http_method_and_path_tokenizer #(
    .MAX_TOKENS   (MaxTokens),
    .MAX_TOKEN_LEN(MaxTokenLen)
  ) DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .text_byte_i,
    .end_of_text_i,
    .out_valid_o,
    .out_stall_i,
    .record_kind_o,
    .method_code_o,
    .token_number_o,
    .byte_position_o,
    .token_byte_o,
    .token_length_o,
    .tokens_found_o,
    .method_error_o,
    .length_overflow_o,
    .last_of_run_o
  );

  htok_record_checker #(
    .MAX_TOKENS   (MaxTokens),
    .MAX_TOKEN_LEN(MaxTokenLen)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i       (in_stall_o),
    .text_byte_i,
    .end_of_text_i,
    .out_valid_i      (out_valid_o),
    .out_stall_i,
    .record_kind_i    (record_kind_o),
    .method_code_i    (method_code_o),
    .token_number_i   (token_number_o),
    .byte_position_i  (byte_position_o),
    .token_byte_i     (token_byte_o),
    .token_length_i   (token_length_o),
    .tokens_found_i   (tokens_found_o),
    .method_error_i   (method_error_o),
    .length_overflow_i(length_overflow_o),
    .last_of_run_i    (last_of_run_o),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding),
    .records_checked_o(records_checked)
  );

  // The receiver stalls at random at the current rate. When asked, it holds off
  // for a long, counted stretch while the sender keeps offering bytes, so the
  // record queue inside the block fills and the input side stalls too.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // The watchdog ends a run in which neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void add_text(string s);
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
  endfunction

  function automatic string method_word(int idx);
    case (idx)
      0:       return "GET";
      1:       return "POST";
      2:       return "PUT";
      3:       return "PATCH";
      default: return "DELETE";
    endcase
  endfunction

  // Any byte that neither splits nor ends a path.
  function automatic logic [7:0] path_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == ChNul || c == ChSlash || c == ChSpace || c == ChCr || c == ChLf
           || c == ChTab)
      c = 8'($urandom_range(255));
    return c;
  endfunction

  // Offers one byte and returns at the edge where its transfer happens. The valid
  // stays high into the next byte unless an idle cycle is drawn.
  task automatic put_byte(logic [7:0] b, logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Sends the bytes built up so far; with close set, the last one carries end_of_text.
  task automatic send_request(bit close);
    for (int k = 0; k < text_q.size(); k++)
      put_byte(text_q[k], close && k == text_q.size() - 1);
    text_q.delete();
    requests++;
  endtask

  // A POST request with a path: most of the random stimulus, since only POST
  // reaches the path splitter. Junk before the first slash, doubled slashes,
  // long tokens and more tokens than the limit show up at random.
  task automatic post_request();
    int n_tok;
    int tlen;
    int term;
    add_text("POST");
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) text_q.push_back(path_char());
    text_q.push_back(ChSlash);
    n_tok = ($urandom_range(7) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 4);
    for (int t = 0; t < n_tok; t++) begin
      tlen = ($urandom_range(15) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
      repeat (tlen) text_q.push_back(path_char());
      if (t < n_tok - 1) begin
        text_q.push_back(ChSlash);
        if ($urandom_range(7) == 0) text_q.push_back(ChSlash);
      end
    end
    term = $urandom_range(5);
    case (term)
      0: text_q.push_back(ChSpace);
      1: text_q.push_back(ChCr);
      2: text_q.push_back(ChLf);
      3: text_q.push_back(ChTab);
      4: text_q.push_back(ChNul);
      default: ;
    endcase
    // Bytes after the summary are ignored until the end of text arrives.
    if (term < 4 && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 2)) text_q.push_back(8'($urandom_range(255)));
    send_request(term == 5 || term < 4 || $urandom_range(1) == 1);
  endtask

  initial begin
    int    pick;
    int    idx;
    int    cut;
    int    stage;
    string word;
    stage = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a leading zero byte, an unknown method, an end during the
    // method match, PUT, PATCH reported as PUT, a POST path with an empty token
    // ended by a zero byte, and a POST that never reaches a slash.
    text_q.push_back(ChNul);
    send_request(1'b0);
    add_text("Q");
    send_request(1'b1);
    add_text("GE");
    send_request(1'b1);
    add_text("PUT");
    send_request(1'b1);
    add_text("POST /a//");
    text_q.push_back(ChNul);
    send_request(1'b0);
    add_text("POST");
    text_q.push_back(8'hff);
    send_request(1'b1);
    add_text("PATCH");
    send_request(1'b1);

    // Random part in three idling modes: a busy receiver, then a slow sender,
    // then full speed opened by a long receiver hold.
    while (bytes_sent < ItemTarget) begin
      if (stage == 0 && bytes_sent >= ItemTarget / 3) begin
        stage = 1;
        send_idle_pct  = 81;
        recv_stall_pct = 7;
      end else if (stage == 1 && bytes_sent >= 2 * ItemTarget / 3) begin
        // The sender pauses until every outstanding record has come out.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
        stage = 2;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        post_request();
      end else if (pick < 75) begin
        // A method other than POST; what follows it is ignored.
        idx = $urandom_range(3);
        if (idx >= 1) idx++;
        add_text(method_word(idx));
        repeat ($urandom_range(3)) text_q.push_back(8'($urandom_range(255)));
        send_request(1'b1);
      end else if (pick < 90) begin
        // A method cut short, sometimes followed by a wrong byte.
        word = method_word($urandom_range(4));
        cut = $urandom_range(1, word.len() - 1);
        for (int k = 0; k < cut; k++) text_q.push_back(word[k]);
        if ($urandom_range(1) == 1) text_q.push_back(8'($urandom_range(255)));
        send_request(1'b1);
      end else begin
        // Noise, at times left open so that it runs into the next request.
        repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(255)));
        send_request($urandom_range(3) != 0);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Run covered %0d requests of %0d bytes under three idling modes and a long",
             requests, bytes_sent);
    $display("output hold; %0d records were checked against the prediction.",
             records_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
